[rtl/mtrr_pkg.sv]
// Shared types, constants and helpers for the MTRR memory type resolver.
// No dependencies; imported by mtrr_range_cmp and mtrr_memory_type_resolver.
`timescale 1ns / 1ps

package mtrr_pkg;

    localparam int ADDR_W         = 52;
    localparam int WORD_W         = 64;
    localparam int TYPE_W         = 8;
    localparam int IDX_W          = 4;
    localparam int OP_W           = 2;
    localparam int FIXED_WORDS    = 11;
    localparam int FIX_IDX_W      = 4;
    localparam int LANE_W         = 3;
    localparam int VAR_RANGES_DEF = 8;
    localparam int VAR_COUNT_W    = 4;
    localparam int VAR_COUNT_RST  = 8;
    localparam int PA_BITS_W      = 6;
    localparam int PA_MIN         = 36;
    localparam int PA_MAX         = 52;
    localparam int VALID_BIT      = 11;
    localparam int PAGE_BITS      = 12;
    localparam int LOW_MEG_BITS   = 20;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 8;
    localparam int S_DATA_W       = 120;
    localparam int M_DATA_W       = 16;

    localparam logic [TYPE_W-1:0] TYPE_UC = 8'h00;
    localparam logic [TYPE_W-1:0] TYPE_WC = 8'h01;
    localparam logic [TYPE_W-1:0] TYPE_WT = 8'h04;
    localparam logic [TYPE_W-1:0] TYPE_WP = 8'h05;
    localparam logic [TYPE_W-1:0] TYPE_WB = 8'h06;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP   = 2'd0,
        OP_WR_FIXED = 2'd1,
        OP_WR_BASE  = 2'd2,
        OP_WR_MASK  = 2'd3
    } op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MTRR_EN   = 3'd0,
        CFG_FIXED_EN  = 3'd1,
        CFG_DEF_TYPE  = 3'd2,
        CFG_VAR_COUNT = 3'd3,
        CFG_PA_BITS   = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FIXED,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              hit;
        logic [TYPE_W-1:0] mtype;
    } range_hit_t;

    typedef struct packed {
        logic [FIX_IDX_W-1:0] word;
        logic [LANE_W-1:0]    lane;
    } fixed_pos_t;

    function automatic logic legal_type(input logic [TYPE_W-1:0] t);
        return (t == TYPE_UC) || (t == TYPE_WC) || (t == TYPE_WT) ||
               (t == TYPE_WP) || (t == TYPE_WB);
    endfunction

    // 64K lanes in word 0, 16K lanes in words 1..2, 4K lanes in words 3..10
    function automatic fixed_pos_t fixed_sel(input logic [LOW_MEG_BITS-1:0] a);
        fixed_pos_t p;
        if (!a[19]) begin
            p.word = '0;
            p.lane = a[18:16];
        end else if (!a[18]) begin
            p.word = FIX_IDX_W'(1) + {3'b000, a[17]};
            p.lane = a[16:14];
        end else begin
            p.word = FIX_IDX_W'(3) + {1'b0, a[17:15]};
            p.lane = a[14:12];
        end
        return p;
    endfunction

    // all-ones below the saturated physical address width
    function automatic logic [ADDR_W-1:0] addr_mask(input logic [PA_BITS_W-1:0] bits);
        logic [PA_BITS_W-1:0] sat;
        sat = bits;
        if (bits < PA_BITS_W'(PA_MIN)) sat = PA_BITS_W'(PA_MIN);
        if (bits > PA_BITS_W'(PA_MAX)) sat = PA_BITS_W'(PA_MAX);
        return ~({ADDR_W{1'b1}} << sat);
    endfunction

endpackage

[rtl/mtrr_range_cmp.sv]
// Variable range match unit: one base/mask pair against one address.
// Depends on mtrr_pkg.
`timescale 1ns / 1ps

module mtrr_range_cmp (
    input  logic [mtrr_pkg::ADDR_W-1:0] addr,
    input  logic [mtrr_pkg::WORD_W-1:0] base,
    input  logic [mtrr_pkg::WORD_W-1:0] mask,
    input  logic [mtrr_pkg::ADDR_W-1:0] last_mask,
    output mtrr_pkg::range_hit_t        hit
);
    import mtrr_pkg::*;

    logic [ADDR_W-1:0] range_begin;
    logic [ADDR_W-1:0] range_len;
    logic [ADDR_W:0]   diff;

    assign range_begin = {base[ADDR_W-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
    assign range_len   = ~{mask[ADDR_W-1:PAGE_BITS], {PAGE_BITS{1'b0}}} & last_mask;
    // borrow out means address below begin; otherwise offset against length
    assign diff        = {1'b0, addr} - {1'b0, range_begin};

    assign hit.hit   = mask[VALID_BIT] && !diff[ADDR_W] && (diff[ADDR_W-1:0] <= range_len);
    assign hit.mtype = base[TYPE_W-1:0];

endmodule

[rtl/mtrr_memory_type_resolver.sv]
// MTRR memory type resolver, top level; depends on mtrr_pkg and mtrr_range_cmp.
// A write word passes through ST_FINISH; a lookup passes ST_CHECK, then ST_FINISH directly
// (disabled or out of width), via ST_FIXED (fixed range) or via ST_SCAN, which walks
// var_count pairs (capped at VAR_RANGES) one a cycle through a single range compare unit.
// Only one word is in flight at a time; a result held back by m_tready stalls the next word.
// Reset (aresetn, synchronous, active low) clears all tables and config to defaults.
`timescale 1ns / 1ps

module mtrr_memory_type_resolver #(
    parameter int VAR_RANGES = mtrr_pkg::VAR_RANGES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write port
    input  logic                              cfg_wr_en,
    input  logic [mtrr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mtrr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mtrr_pkg::S_DATA_W-1:0]     s_tdata,  // entry_index, write_value, address
    input  logic [mtrr_pkg::OP_W-1:0]         s_tuser,  // operation
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mtrr_pkg::M_DATA_W-1:0]     m_tdata,  // mem_type, conflict, bad_type, pad
    output logic                              m_tuser   // is_lookup
);
    import mtrr_pkg::*;

    localparam int VIDX_W = (VAR_RANGES > 1) ? $clog2(VAR_RANGES) : 1;
    localparam int CNT_W  = $clog2(VAR_RANGES + 1);
    localparam int N_RST  = (VAR_COUNT_RST < VAR_RANGES) ? VAR_COUNT_RST : VAR_RANGES;
    localparam logic [VAR_COUNT_W:0] VR_LIM = (VAR_COUNT_W + 1)'(VAR_RANGES);

    // input word fields
    logic [IDX_W-1:0]  in_idx;
    logic [WORD_W-1:0] in_value;
    logic [ADDR_W-1:0] in_addr;
    op_t               in_op;

    assign in_idx   = s_tdata[IDX_W-1:0];
    assign in_value = s_tdata[IDX_W+WORD_W-1:IDX_W];
    assign in_addr  = s_tdata[IDX_W+WORD_W+ADDR_W-1:IDX_W+WORD_W];
    assign in_op    = op_t'(s_tuser);

    // config
    logic              mtrr_en_reg;
    logic              fixed_en_reg;
    logic [TYPE_W-1:0] def_type_reg;
    logic [CNT_W-1:0]  var_n_reg;
    logic [ADDR_W-1:0] last_mask_reg;
    logic [VAR_COUNT_W:0] cfg_cnt;

    assign cfg_cnt = {1'b0, cfg_wdata[VAR_COUNT_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mtrr_en_reg   <= 1'b0;
            fixed_en_reg  <= 1'b0;
            def_type_reg  <= TYPE_UC;
            var_n_reg     <= CNT_W'(N_RST);
            last_mask_reg <= addr_mask(PA_BITS_W'(PA_MIN));
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MTRR_EN:   mtrr_en_reg  <= cfg_wdata[0];
                CFG_FIXED_EN:  fixed_en_reg <= cfg_wdata[0];
                CFG_DEF_TYPE:  def_type_reg <= cfg_wdata[TYPE_W-1:0];
                CFG_VAR_COUNT: var_n_reg    <= (cfg_cnt > VR_LIM) ? CNT_W'(VR_LIM)
                                                                  : CNT_W'(cfg_cnt);
                CFG_PA_BITS:   last_mask_reg <= addr_mask(cfg_wdata[PA_BITS_W-1:0]);
                default: ;
            endcase
        end
    end

    // range tables
    logic [WORD_W-1:0] fixed_words_reg [FIXED_WORDS];
    logic [WORD_W-1:0] var_base_reg    [VAR_RANGES];
    logic [WORD_W-1:0] var_mask_reg    [VAR_RANGES];
    logic              fix_we, base_we, mask_we;
    logic              fix_idx_ok, var_idx_ok;

    assign fix_idx_ok = in_idx < IDX_W'(FIXED_WORDS);
    assign var_idx_ok = {1'b0, in_idx} < VR_LIM;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FIXED_WORDS; i++) fixed_words_reg[i] <= '0;
            for (int i = 0; i < VAR_RANGES; i++) begin
                var_base_reg[i] <= '0;
                var_mask_reg[i] <= '0;
            end
        end else begin
            if (fix_we)  fixed_words_reg[in_idx[FIX_IDX_W-1:0]] <= in_value;
            if (base_we) var_base_reg[in_idx[VIDX_W-1:0]] <= in_value;
            if (mask_we) var_mask_reg[in_idx[VIDX_W-1:0]] <= in_value;
        end
    end

    // sequencer state
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              have_reg, have_next;
    logic              any_uc_reg, any_uc_next;
    logic              mixed_reg, mixed_next;
    logic [TYPE_W-1:0] acc_reg, acc_next;
    logic [TYPE_W-1:0] pend_type_reg, pend_type_next;
    logic              pend_conflict_reg, pend_conflict_next;
    logic              pend_lookup_reg, pend_lookup_next;
    logic              out_valid_reg, out_valid_next;
    logic [TYPE_W-1:0] out_type_reg, out_type_next;
    logic              out_conflict_reg, out_conflict_next;
    logic              out_bad_reg, out_bad_next;
    logic              out_lookup_reg, out_lookup_next;

    // shared range compare, walked over the pairs by idx_reg
    range_hit_t        rhit;
    fixed_pos_t        fpos;
    logic [WORD_W-1:0] fword;

    mtrr_range_cmp u_range_cmp (
        .addr      (addr_reg),
        .base      (var_base_reg[idx_reg[VIDX_W-1:0]]),
        .mask      (var_mask_reg[idx_reg[VIDX_W-1:0]]),
        .last_mask (last_mask_reg),
        .hit       (rhit)
    );

    assign fpos  = fixed_sel(addr_reg[LOW_MEG_BITS-1:0]);
    assign fword = fixed_words_reg[fpos.word];

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next         = state_reg;
        addr_next          = addr_reg;
        idx_next           = idx_reg;
        have_next          = have_reg;
        any_uc_next        = any_uc_reg;
        mixed_next         = mixed_reg;
        acc_next           = acc_reg;
        pend_type_next     = pend_type_reg;
        pend_conflict_next = pend_conflict_reg;
        pend_lookup_next   = pend_lookup_reg;
        out_valid_next     = out_valid_reg && !m_tready;
        out_type_next      = out_type_reg;
        out_conflict_next  = out_conflict_reg;
        out_bad_next       = out_bad_reg;
        out_lookup_next    = out_lookup_reg;
        fix_we             = 1'b0;
        base_we            = 1'b0;
        mask_we            = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    pend_type_next     = TYPE_UC;
                    pend_conflict_next = 1'b0;
                    pend_lookup_next   = 1'b0;
                    state_next         = ST_FINISH;
                    case (in_op)
                        OP_LOOKUP: begin
                            addr_next  = in_addr;
                            state_next = ST_CHECK;
                        end
                        OP_WR_FIXED: fix_we  = fix_idx_ok;
                        OP_WR_BASE:  base_we = var_idx_ok;
                        OP_WR_MASK:  mask_we = var_idx_ok;
                        default: ;
                    endcase
                end
            end
            ST_CHECK: begin
                pend_lookup_next   = 1'b1;
                pend_conflict_next = 1'b0;
                if (!mtrr_en_reg || |(addr_reg & ~last_mask_reg)) begin
                    pend_type_next = TYPE_UC;
                    state_next     = ST_FINISH;
                end else if (fixed_en_reg && addr_reg[ADDR_W-1:LOW_MEG_BITS] == '0) begin
                    state_next = ST_FIXED;
                end else begin
                    idx_next    = '0;
                    have_next   = 1'b0;
                    any_uc_next = 1'b0;
                    mixed_next  = 1'b0;
                    acc_next    = TYPE_UC;
                    state_next  = ST_SCAN;
                end
            end
            ST_FIXED: begin
                pend_type_next = fword[{fpos.lane, 3'b000} +: TYPE_W];
                state_next     = ST_FINISH;
            end
            ST_SCAN: begin
                if (idx_reg == var_n_reg) begin
                    if (any_uc_reg) begin
                        pend_type_next = TYPE_UC;
                    end else if (mixed_reg) begin
                        pend_type_next     = TYPE_UC;
                        pend_conflict_next = 1'b1;
                    end else if (have_reg) begin
                        pend_type_next = acc_reg;
                    end else begin
                        pend_type_next = def_type_reg;
                    end
                    state_next = ST_FINISH;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                    if (rhit.hit) begin
                        if (rhit.mtype == TYPE_UC) begin
                            any_uc_next = 1'b1;
                        end else if (!have_reg) begin
                            acc_next  = rhit.mtype;
                            have_next = 1'b1;
                        end else if (rhit.mtype != acc_reg) begin
                            // WT and WB together resolve to WT
                            if ((rhit.mtype == TYPE_WT && acc_reg == TYPE_WB) ||
                                (rhit.mtype == TYPE_WB && acc_reg == TYPE_WT))
                                acc_next = TYPE_WT;
                            else
                                mixed_next = 1'b1;
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next    = 1'b1;
                    out_type_next     = pend_type_reg;
                    out_conflict_next = pend_conflict_reg;
                    out_bad_next      = !legal_type(pend_type_reg);
                    out_lookup_next   = pend_lookup_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg          <= addr_next;
        idx_reg           <= idx_next;
        have_reg          <= have_next;
        any_uc_reg        <= any_uc_next;
        mixed_reg         <= mixed_next;
        acc_reg           <= acc_next;
        pend_type_reg     <= pend_type_next;
        pend_conflict_reg <= pend_conflict_next;
        pend_lookup_reg   <= pend_lookup_next;
        out_type_reg      <= out_type_next;
        out_conflict_reg  <= out_conflict_next;
        out_bad_reg       <= out_bad_next;
        out_lookup_reg    <= out_lookup_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - TYPE_W - 2){1'b0}}, out_bad_reg, out_conflict_reg,
                       out_type_reg};
    assign m_tuser  = out_lookup_reg;

    // a conflict always answers UC, which is legal
    a_conflict_uc: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_conflict_reg |-> out_type_reg == TYPE_UC && !out_bad_reg)
        else $error("conflict word without UC type");

    a_write_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_lookup_reg |->
            out_type_reg == TYPE_UC && !out_conflict_reg && !out_bad_reg)
        else $error("write acknowledge carries lookup fields");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("word accepted while previous one in flight");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> idx_reg <= var_n_reg)
        else $error("pair walk ran past var_count");

endmodule
